### hdl/snz_pkg.sv
// snz_pkg: constants, gradient table and shared types for the simplex noise pipeline
// used by snz_cell, snz_vertex, snz_out and simplex_noise_2d; no dependencies

package snz_pkg;

   localparam int CELL_STAGES = 5;
   localparam int VTX_STAGES = 7;
   localparam int OUT_STAGES = 3;
   localparam int PIPE_STAGES = CELL_STAGES + VTX_STAGES + OUT_STAGES;
   localparam int VERTICES = 3;

   localparam logic [63:0] PRIME_X = 64'h5205402B9270C86F;
   localparam logic [63:0] PRIME_Y = 64'h598CD327003817B5;
   localparam logic [63:0] HASH_MUL = 64'h53A3F72DEEC546F5;

   localparam logic signed [30:0] SKEW_Q30 = 31'sd393016785;
   localparam logic signed [29:0] UNSKEW_Q30 = -30'sd226908346;
   localparam logic [29:0] Q30_HALF = 30'd536870912;
   localparam logic signed [31:0] FAR_OFS = 32'sd619925132;
   localparam logic signed [31:0] SIDE_NEAR = 32'sd226908346;
   localparam logic signed [31:0] SIDE_FAR = 32'sd846833478;
   localparam logic signed [30:0] INV_2N_Q24 = 31'sd837492236;

   localparam int DIR_COUNT = 24;
   localparam logic [7:0] DIR_RECIP = 8'd171;
   localparam int DIR_RECIP_SH = 12;

   localparam logic signed [31:0] G1 = 32'sd410903207;
   localparam logic signed [31:0] G2 = 32'sd992008094;
   localparam logic signed [31:0] G3 = 32'sd140151432;
   localparam logic signed [31:0] G4 = 32'sd1064555814;
   localparam logic signed [31:0] G5 = 32'sd653652607;
   localparam logic signed [31:0] G6 = 32'sd851856663;

   typedef struct packed {
      logic [63:0] key;
      logic signed [31:0] dx;
      logic signed [31:0] dy;
   } vtx_type;

   typedef struct packed {
      logic signed [31:0] gx;
      logic signed [31:0] gy;
   } grad_type;

   function automatic grad_type grad_dir(input logic [4:0] dir);
      grad_type g;
      unique case (dir)
         5'd0: g = '{G1, G2};
         5'd1: g = '{G2, G1};
         5'd2: g = '{G2, -G1};
         5'd3: g = '{G1, -G2};
         5'd4: g = '{-G1, -G2};
         5'd5: g = '{-G2, -G1};
         5'd6: g = '{-G2, G1};
         5'd7: g = '{-G1, G2};
         5'd8: g = '{G3, G4};
         5'd9: g = '{G5, G6};
         5'd10: g = '{G6, G5};
         5'd11: g = '{G4, G3};
         5'd12: g = '{G4, -G3};
         5'd13: g = '{G6, -G5};
         5'd14: g = '{G5, -G6};
         5'd15: g = '{G3, -G4};
         5'd16: g = '{-G3, -G4};
         5'd17: g = '{-G5, -G6};
         5'd18: g = '{-G6, -G5};
         5'd19: g = '{-G4, -G3};
         5'd20: g = '{-G4, G3};
         5'd21: g = '{-G6, G5};
         5'd22: g = '{-G5, G6};
         5'd23: g = '{-G3, G4};
         default: g = '{32'sd0, 32'sd0};
      endcase
      return g;
   endfunction

endpackage

### hdl/snz_cell.sv
// snz_cell: skew, cell floor, unskew offsets and vertex hash keys (five stages)
// depends on snz_pkg

module snz_cell #(
   parameter int COORD_FRAC_BITS = 16
) (
   input  logic clock,
   input  logic [snz_pkg::CELL_STAGES-1:0] stage_en,
   input  logic [63:0] seed,
   input  logic signed [31:0] coord_x,
   input  logic signed [31:0] coord_y,
   output snz_pkg::vtx_type [snz_pkg::VERTICES-1:0] vtx
);
   import snz_pkg::*;

   localparam int XS_W = 64 - COORD_FRAC_BITS;
   localparam int XB_W = XS_W - 30;
   localparam int SC = 30 - COORD_FRAC_BITS;

   // stage 0
   logic signed [32:0] sum_xy;
   logic signed [63:0] sk0_in, sk0_ff;
   logic signed [31:0] x0_ff, y0_ff;

   // stage 1
   logic signed [63:0] s1;
   logic [XS_W-1:0] xs1, ys1;
   logic signed [XB_W-1:0] xb1_ff, yb1_ff;
   logic [29:0] xi1_ff, yi1_ff;

   // stage 2
   logic [30:0] u2;
   logic signed [61:0] tp2_in, tp2_ff;
   logic signed [XB_W+32:0] pxl2_in, pxl2_ff, pyl2_in, pyl2_ff;
   logic [31:0] pxh2_in, pxh2_ff, pyh2_in, pyh2_ff;
   logic [29:0] xi2_ff, yi2_ff;

   // stage 3
   logic signed [61:0] t3_full;
   logic signed [31:0] t3;
   logic signed [31:0] dx3_in, dy3_in, dx3_ff, dy3_ff;
   logic [63:0] hx3_in, hy3_in, hx3_ff, hy3_ff;

   // stage 4
   logic [63:0] hxp4, hyp4;
   logic upper4;
   vtx_type [VERTICES-1:0] vtx4_in, vtx4_ff;

   assign sum_xy = {coord_x[31], coord_x} + {coord_y[31], coord_y};
   assign sk0_in = sum_xy * SKEW_Q30;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         x0_ff <= coord_x;
         y0_ff <= coord_y;
         sk0_ff <= sk0_in;
      end
   end

   assign s1 = sk0_ff >>> COORD_FRAC_BITS;
   assign xs1 = ({{(XS_W-32){x0_ff[31]}}, x0_ff} << SC) + s1[XS_W-1:0];
   assign ys1 = ({{(XS_W-32){y0_ff[31]}}, y0_ff} << SC) + s1[XS_W-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         xb1_ff <= $signed(xs1[XS_W-1:30]);
         yb1_ff <= $signed(ys1[XS_W-1:30]);
         xi1_ff <= xs1[29:0];
         yi1_ff <= ys1[29:0];
      end
   end

   assign u2 = {1'b0, xi1_ff} + {1'b0, yi1_ff};
   assign tp2_in = $signed({1'b0, u2}) * UNSKEW_Q30;
   assign pxl2_in = xb1_ff * $signed({1'b0, PRIME_X[31:0]});
   assign pyl2_in = yb1_ff * $signed({1'b0, PRIME_Y[31:0]});
   assign pxh2_in = {{(32-XB_W){xb1_ff[XB_W-1]}}, xb1_ff} * PRIME_X[63:32];
   assign pyh2_in = {{(32-XB_W){yb1_ff[XB_W-1]}}, yb1_ff} * PRIME_Y[63:32];

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         tp2_ff <= tp2_in;
         pxl2_ff <= pxl2_in;
         pyl2_ff <= pyl2_in;
         pxh2_ff <= pxh2_in;
         pyh2_ff <= pyh2_in;
         xi2_ff <= xi1_ff;
         yi2_ff <= yi1_ff;
      end
   end

   assign t3_full = tp2_ff >>> 30;
   assign t3 = t3_full[31:0];
   assign dx3_in = {2'b00, xi2_ff} + t3;
   assign dy3_in = {2'b00, yi2_ff} + t3;
   assign hx3_in = {{(31-XB_W){pxl2_ff[XB_W+32]}}, pxl2_ff} + {pxh2_ff, 32'd0};
   assign hy3_in = {{(31-XB_W){pyl2_ff[XB_W+32]}}, pyl2_ff} + {pyh2_ff, 32'd0};

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         dx3_ff <= dx3_in;
         dy3_ff <= dy3_in;
         hx3_ff <= hx3_in;
         hy3_ff <= hy3_in;
      end
   end

   assign hxp4 = hx3_ff + PRIME_X;
   assign hyp4 = hy3_ff + PRIME_Y;
   assign upper4 = dy3_ff > dx3_ff;

   always_comb begin
      vtx4_in[0].key = seed ^ hx3_ff ^ hy3_ff;
      vtx4_in[0].dx = dx3_ff;
      vtx4_in[0].dy = dy3_ff;
      vtx4_in[1].key = seed ^ hxp4 ^ hyp4;
      vtx4_in[1].dx = dx3_ff - FAR_OFS;
      vtx4_in[1].dy = dy3_ff - FAR_OFS;
      if (upper4) begin
         vtx4_in[2].key = seed ^ hx3_ff ^ hyp4;
         vtx4_in[2].dx = dx3_ff + SIDE_NEAR;
         vtx4_in[2].dy = dy3_ff - SIDE_FAR;
      end else begin
         vtx4_in[2].key = seed ^ hxp4 ^ hy3_ff;
         vtx4_in[2].dx = dx3_ff - SIDE_FAR;
         vtx4_in[2].dy = dy3_ff + SIDE_NEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         vtx4_ff <= vtx4_in;
      end
   end

   assign vtx = vtx4_ff;

endmodule

### hdl/snz_vertex.sv
// snz_vertex: one simplex vertex, hash to gradient, falloff a^4 and weighted dot (seven stages)
// depends on snz_pkg

module snz_vertex #(
   parameter int GRADIENT_COUNT = 128
) (
   input  logic clock,
   input  logic [snz_pkg::VTX_STAGES-1:0] stage_en,
   input  snz_pkg::vtx_type vtx_in,
   output logic signed [63:0] weight
);
   import snz_pkg::*;

   localparam int LG = $clog2(GRADIENT_COUNT);
   localparam int SH = 65 - LG;

   // stage 0
   logic [63:0] hll0_in, hll0_ff;
   logic [31:0] hcr0_in, hcr0_ff;
   logic signed [63:0] dxx0_in, dyy0_in, dxx0_ff, dyy0_ff;
   logic signed [31:0] dx0_ff, dy0_ff;

   // stage 1
   logic [63:0] h1_in, h1_ff;
   logic signed [35:0] a1_full;
   logic live1_in, live1_ff;
   logic [29:0] a1_ff;
   logic signed [31:0] dx1_ff, dy1_ff;

   // stage 2
   logic [63:0] hs2, hm2;
   logic [LG-1:0] idx2_ff;
   logic [59:0] a2p2_in, a2p2_ff;
   logic live2_ff;
   logic signed [31:0] dx2_ff, dy2_ff;

   // stage 3
   logic [29:0] a2_3;
   logic [59:0] a4p3_in, a4p3_ff;
   logic [7:0] idx3;
   logic [15:0] qp3;
   logic [7:0] q3, rem3;
   logic [4:0] dir3_ff;
   logic live3_ff;
   logic signed [31:0] dx3_ff, dy3_ff;

   // stage 4
   grad_type g4;
   logic signed [63:0] pgx4_in, pgy4_in, pgx4_ff, pgy4_ff;
   logic [29:0] a4_4_ff;
   logic live4_ff;

   // stage 5
   logic signed [34:0] dot5_in, dot5_ff;
   logic [29:0] a4_5_ff;
   logic live5_ff;

   // stage 6
   logic signed [63:0] w6_in, w6_ff;

   assign hll0_in = vtx_in.key[31:0] * HASH_MUL[31:0];
   assign hcr0_in = vtx_in.key[31:0] * HASH_MUL[63:32] + vtx_in.key[63:32] * HASH_MUL[31:0];
   assign dxx0_in = vtx_in.dx * vtx_in.dx;
   assign dyy0_in = vtx_in.dy * vtx_in.dy;

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         hll0_ff <= hll0_in;
         hcr0_ff <= hcr0_in;
         dxx0_ff <= dxx0_in;
         dyy0_ff <= dyy0_in;
         dx0_ff <= vtx_in.dx;
         dy0_ff <= vtx_in.dy;
      end
   end

   assign h1_in = hll0_ff + {hcr0_ff, 32'd0};
   assign a1_full = 36'(Q30_HALF) - {2'b00, dxx0_ff[63:30]} - {2'b00, dyy0_ff[63:30]};
   assign live1_in = !a1_full[35] && (a1_full != 36'sd0);

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         h1_ff <= h1_in;
         live1_ff <= live1_in;
         a1_ff <= live1_in ? a1_full[29:0] : 30'd0;
         dx1_ff <= dx0_ff;
         dy1_ff <= dy0_ff;
      end
   end

   assign hs2 = $signed(h1_ff) >>> SH;
   assign hm2 = h1_ff ^ hs2;
   assign a2p2_in = a1_ff * a1_ff;

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         idx2_ff <= hm2[LG:1];
         a2p2_ff <= a2p2_in;
         live2_ff <= live1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
      end
   end

   // gradient number modulo 24 by reciprocal multiply
   assign a2_3 = a2p2_ff[59:30];
   assign a4p3_in = a2_3 * a2_3;
   assign idx3 = 8'(idx2_ff);
   assign qp3 = idx3 * DIR_RECIP;
   assign q3 = 8'(qp3 >> DIR_RECIP_SH);
   assign rem3 = idx3 - q3 * 8'(DIR_COUNT);

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         a4p3_ff <= a4p3_in;
         dir3_ff <= rem3[4:0];
         live3_ff <= live2_ff;
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
      end
   end

   assign g4 = grad_dir(dir3_ff);
   assign pgx4_in = g4.gx * dx3_ff;
   assign pgy4_in = g4.gy * dy3_ff;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         pgx4_ff <= pgx4_in;
         pgy4_ff <= pgy4_in;
         a4_4_ff <= a4p3_ff[59:30];
         live4_ff <= live3_ff;
      end
   end

   assign dot5_in = $signed(pgx4_ff[63:30]) + $signed(pgy4_ff[63:30]);

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         dot5_ff <= dot5_in;
         a4_5_ff <= a4_4_ff;
         live5_ff <= live4_ff;
      end
   end

   assign w6_in = live5_ff ? $signed({1'b0, a4_5_ff}) * dot5_ff : 64'sd0;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         w6_ff <= w6_in;
      end
   end

   assign weight = w6_ff;

endmodule

### hdl/snz_out.sv
// snz_out: vertex sum, clamp, rescale to [0,1], round and saturate (three stages)
// depends on snz_pkg

module snz_out #(
   parameter int OUTPUT_BITS = 16
) (
   input  logic clock,
   input  logic [snz_pkg::OUT_STAGES-1:0] stage_en,
   input  logic signed [63:0] weight_0,
   input  logic signed [63:0] weight_1,
   input  logic signed [63:0] weight_2,
   output logic [15:0] noise_value
);
   import snz_pkg::*;

   localparam logic signed [35:0] V_MAX = 36'sd1073741824;
   localparam logic signed [35:0] V_MIN = -36'sd1073741824;
   localparam logic signed [63:0] RND = (64'sd1 <<< 53) + (64'sd1 <<< (53 - OUTPUT_BITS));
   localparam logic signed [63:0] R_MAX = (64'sd1 <<< OUTPUT_BITS) - 64'sd1;

   logic signed [35:0] sum0;
   logic signed [35:0] clip0;
   logic signed [31:0] v0_ff;
   logic signed [63:0] rp1_in, rp1_ff;
   logic signed [63:0] r2;
   logic [OUTPUT_BITS-1:0] rc2;
   logic [15:0] noise_ff;

   assign sum0 = $signed(weight_0[63:30]) + $signed(weight_1[63:30])
               + $signed(weight_2[63:30]);

   always_comb begin
      priority if (sum0 > V_MAX) begin
         clip0 = V_MAX;
      end else if (sum0 < V_MIN) begin
         clip0 = V_MIN;
      end else begin
         clip0 = sum0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         v0_ff <= clip0[31:0];
      end
   end

   assign rp1_in = v0_ff * INV_2N_Q24 + RND;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         rp1_ff <= rp1_in;
      end
   end

   assign r2 = rp1_ff >>> (54 - OUTPUT_BITS);

   always_comb begin
      priority if (r2 < 64'sd0) begin
         rc2 = '0;
      end else if (r2 > R_MAX) begin
         rc2 = '1;
      end else begin
         rc2 = r2[OUTPUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         noise_ff <= 16'(rc2);
      end
   end

   assign noise_value = noise_ff;

endmodule

### hdl/simplex_noise_2d.sv
// simplex_noise_2d: 2D simplex lattice noise, one coordinate pair in, one value out
// throughput: one beat per cycle while req_stall is low; bubbles in the 15-stage pipeline close up under rsp_stall
// reset: synchronous, clears the stage valid bits and sets the seed to zero
// depends on snz_pkg, snz_cell, snz_vertex, snz_out

module simplex_noise_2d #(
   parameter int GRADIENT_COUNT = 128,
   parameter int COORD_FRAC_BITS = 16,
   parameter int OUTPUT_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_en,
   input  logic signed [63:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [15:0] rsp_noise_value
);
   import snz_pkg::*;

   localparam int NS = PIPE_STAGES;
   localparam int V0 = CELL_STAGES;
   localparam int O0 = CELL_STAGES + VTX_STAGES;

   logic [63:0] seed_ff;
   logic [NS-1:0] v_ff, v_in, adv;
   vtx_type [VERTICES-1:0] vtx;
   logic signed [63:0] weight [VERTICES];

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 64'd0;
      end else if (csr_write_en) begin
         seed_ff <= csr_write_data;
      end
   end

   // a stage moves when the output is free or a bubble sits at or after it
   for (genvar k = 0; k < NS; k++) begin : g_adv
      assign adv[k] = !rsp_stall || !(&v_ff[NS-1:k]);
      if (k == 0) begin : g_first
         assign v_in[k] = adv[k] ? req_valid : v_ff[k];
      end else begin : g_rest
         assign v_in[k] = adv[k] ? v_ff[k-1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = v_ff[NS-1];

   snz_cell #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_cell (
      .clock(clock),
      .stage_en(adv[V0-1:0]),
      .seed(seed_ff),
      .coord_x(req_coord_x),
      .coord_y(req_coord_y),
      .vtx(vtx)
   );

   for (genvar i = 0; i < VERTICES; i++) begin : g_vtx
      snz_vertex #(
         .GRADIENT_COUNT(GRADIENT_COUNT)
      ) u_vertex (
         .clock(clock),
         .stage_en(adv[O0-1:V0]),
         .vtx_in(vtx[i]),
         .weight(weight[i])
      );
   end

   snz_out #(
      .OUTPUT_BITS(OUTPUT_BITS)
   ) u_out (
      .clock(clock),
      .stage_en(adv[NS-1:O0]),
      .weight_0(weight[0]),
      .weight_1(weight[1]),
      .weight_2(weight[2]),
      .noise_value(rsp_noise_value)
   );

endmodule

### hdl/snz_check.sv
// snz_check: port-level checks on simplex_noise_2d, bound to the top level
// no package dependency

module snz_check (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic [15:0] rsp_noise_value
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_noise_value))
      else $error("result beat changed while stalled");

   // input is held back only when a result is valid and the output blocked
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the pipeline");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // input never stalled while the output is empty
   a_no_stall_idle: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output empty");

endmodule

bind simplex_noise_2d snz_check u_check (.*);
